// ===== sv/mrqt_pkg.sv =====
// types and constants shared by the quarter-turn matrix rotator
package mrqt_pkg;

    localparam int ELEM_W     = 32;
    localparam int DIM_W      = 4;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // largest dimension a 4-bit register can ask for
    localparam int DIM_LIMIT = 15;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd2;

    typedef enum logic [MODE_W-1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_mode_t;

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

endpackage

// ===== sv/matrix_rotate_quarter_turns_core.sv =====
// quarter-turn matrix rotator: frame memory, load counter and rotated read-out
//
//  channel  direction  handshake              payload
//  cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//  in       in         in_valid / in_ready    element_value
//  out      out        out_valid / out_ready  out_value, out_last
//
// a frame of N = rows * cols elements loads at one element per cycle into the frame memory,
// then reads out at one element per cycle, while the output is not stalled, through the single
// memory read port; the read data is registered before it reaches out_value
// reset is asynchronous and clears control state only; memory contents stay undefined
// the output register stalls the read-out; a new frame loads while the last result waits
// cfg_ready is always high
module matrix_rotate_quarter_turns_core #(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mrqt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mrqt_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [mrqt_pkg::ELEM_W-1:0]        element_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [mrqt_pkg::ELEM_W-1:0]        out_value,
    output logic                               out_last
);
    import mrqt_pkg::*;

    localparam int DIM_CAP = (MAX_DIM < DIM_LIMIT) ? MAX_DIM : DIM_LIMIT;
    localparam int TOT_MAX = DIM_CAP * DIM_CAP;
    localparam int CNT_W   = $clog2(TOT_MAX + 1);
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam logic [DIM_W-1:0] DIM_CAP_V = DIM_W'(DIM_CAP);

    rot_mode_t              mode_reg;
    logic [DIM_W-1:0]       rows_reg;
    logic [DIM_W-1:0]       cols_reg;
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       load_count_reg, load_count_next;
    logic [CNT_W-1:0]       emit_k_reg, emit_k_next;
    logic [CNT_W-1:0]       src_reg, src_next;
    logic [DIM_W-1:0]       r_reg, r_next;
    logic [DIM_W-1:0]       c_reg, c_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_last_reg;
    logic [DATA_WIDTH-1:0]  rd_data_reg;

    logic [DATA_WIDTH-1:0]  frame_store [DEPTH];

    logic [DIM_W-1:0]       n_dim;
    logic [DIM_W-1:0]       m_dim;
    logic [2*DIM_W-1:0]     prod;
    logic [CNT_W-1:0]       total;
    logic [CNT_W-1:0]       n_c;
    logic [DIM_W-1:0]       c_plus;
    logic                   in_fire;
    logic                   frame_done;
    logic                   issue;
    logic                   emit_last;
    logic [ADDR_W-1:0]      wr_addr;
    logic [ADDR_W-1:0]      rd_addr;

    // dimension clamp: zero acts as one, large values saturate
    always_comb
    begin
        if (rows_reg == '0)
            n_dim = DIM_W'(1);
        else if (rows_reg > DIM_CAP_V)
            n_dim = DIM_CAP_V;
        else
            n_dim = rows_reg;

        if (cols_reg == '0)
            m_dim = DIM_W'(1);
        else if (cols_reg > DIM_CAP_V)
            m_dim = DIM_CAP_V;
        else
            m_dim = cols_reg;
    end

    assign prod   = {{DIM_W{1'b0}}, n_dim} * {{DIM_W{1'b0}}, m_dim};
    assign total  = CNT_W'(prod);
    assign n_c    = CNT_W'(n_dim);
    assign c_plus = c_reg + DIM_W'(1);

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_LOAD);
    assign in_fire   = in_valid & in_ready;
    assign frame_done = in_fire &&
        (({1'b0, load_count_reg} + (CNT_W+1)'(1)) >= {1'b0, total});
    assign issue     = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign emit_last = (emit_k_reg == (total - CNT_W'(1)));
    assign wr_addr   = ADDR_W'(load_count_reg);
    assign rd_addr   = ADDR_W'(src_reg);

    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;
    assign out_value = ELEM_W'(rd_data_reg);

    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        emit_k_next     = emit_k_reg;
        src_next        = src_reg;
        r_next          = r_reg;
        c_next          = c_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (frame_done)
                    begin
                        state_next      = ST_EMIT;
                        load_count_next = '0;
                        emit_k_next     = '0;
                        r_next          = '0;
                        c_next          = '0;
                        unique case (mode_reg)
                            ROT_0:   src_next = '0;
                            ROT_90:  src_next = n_c - CNT_W'(1);
                            ROT_180: src_next = total - CNT_W'(1);
                            ROT_270: src_next = total - n_c;
                            default: src_next = '0;
                        endcase
                    end
                    else
                    begin
                        load_count_next = load_count_reg + CNT_W'(1);
                    end
                end
            end
            ST_EMIT:
            begin
                if (issue)
                begin
                    if (emit_last)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        emit_k_next = emit_k_reg + CNT_W'(1);
                        // quarter turns walk the source by column strides
                        unique case (mode_reg)
                            ROT_0:   src_next = src_reg + CNT_W'(1);
                            ROT_180: src_next = src_reg - CNT_W'(1);
                            ROT_90:
                            begin
                                if (r_reg == m_dim - DIM_W'(1))
                                begin
                                    r_next   = '0;
                                    c_next   = c_plus;
                                    src_next = n_c - CNT_W'(1) - CNT_W'(c_plus);
                                end
                                else
                                begin
                                    r_next   = r_reg + DIM_W'(1);
                                    src_next = src_reg + n_c;
                                end
                            end
                            ROT_270:
                            begin
                                if (r_reg == m_dim - DIM_W'(1))
                                begin
                                    r_next   = '0;
                                    c_next   = c_plus;
                                    src_next = total - n_c + CNT_W'(c_plus);
                                end
                                else
                                begin
                                    r_next   = r_reg + DIM_W'(1);
                                    src_next = src_reg - n_c;
                                end
                            end
                            default: src_next = src_reg;
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        if (issue)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= ROT_0;
            rows_reg       <= DIM_RESET;
            cols_reg       <= DIM_RESET;
            state_reg      <= ST_LOAD;
            load_count_reg <= '0;
            emit_k_reg     <= '0;
            src_reg        <= '0;
            r_reg          <= '0;
            c_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_MODE: mode_reg <= rot_mode_t'(cfg_data[MODE_W-1:0]);
                    CFG_ROWS: rows_reg <= cfg_data[DIM_W-1:0];
                    CFG_COLS: cols_reg <= cfg_data[DIM_W-1:0];
                    default:  mode_reg <= mode_reg;
                endcase
            end
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            emit_k_reg     <= emit_k_next;
            src_reg        <= src_next;
            r_reg          <= r_next;
            c_reg          <= c_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // frame memory: writes only while loading, reads only while emitting
    always_ff @(posedge clk)
    begin
        if (in_fire)
            frame_store[wr_addr] <= DATA_WIDTH'(element_value);
        if (issue)
        begin
            rd_data_reg  <= frame_store[rd_addr];
            out_last_reg <= emit_last;
        end
    end

    a_load_idle_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (load_count_reg == '0))
        else $error("load counter not cleared during read-out");

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (emit_k_reg < total))
        else $error("read-out counter past frame size");

    a_emit_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_EMIT) |-> (emit_k_reg == '0) && (r_reg == '0) && (c_reg == '0))
        else $error("read-out did not start at the first element");

    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        issue && emit_last |=> (state_reg == ST_LOAD) && out_valid_reg && out_last_reg)
        else $error("final read did not close the burst");

endmodule
